FILE: design/pdt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pdt_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_format;
  } in_word_t;

  typedef struct packed {
    logic [4:0]  directive_kind;
    logic [1:0]  signedness;
    logic [2:0]  byte_order;
    logic [3:0]  size_code;
    logic [1:0]  count_kind;
    logic [63:0] count_value;
    logic [1:0]  encoding_class;
    logic [2:0]  status;
    logic        last_of_input;
  } out_word_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] kind;
    logic [1:0] sgn;
    logic [2:0] ord;
    logic [3:0] size;
    logic       allow;
  } dec_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_MODS    = 4'b0010,
    PH_DIGITS  = 4'b0100,
    PH_COMMENT = 4'b1000
  } phase_t;

  localparam logic [4:0] K_END   = 5'd0;
  localparam logic [4:0] K_SPACE = 5'd1;
  localparam logic [4:0] K_CMT   = 5'd2;
  localparam logic [4:0] K_INT   = 5'd3;
  localparam logic [4:0] K_UTF8  = 5'd4;
  localparam logic [4:0] K_UU    = 5'd14;
  localparam logic [4:0] K_MIME  = 5'd15;
  localparam logic [4:0] K_B64   = 5'd16;
  localparam logic [4:0] K_PFIX  = 5'd17;
  localparam logic [4:0] K_MOVE  = 5'd19;
  localparam logic [4:0] K_BACK  = 5'd20;
  localparam logic [4:0] K_NULL  = 5'd21;

  localparam logic [1:0] CK_FIXED = 2'd1;
  localparam logic [1:0] CK_MAX   = 2'd2;
  localparam logic [1:0] CK_REL   = 2'd3;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd1;
  localparam logic [2:0] ST_UNKNOWN     = 3'd2;
  localparam logic [2:0] ST_BANG        = 3'd3;
  localparam logic [2:0] ST_DOUBLE_END  = 3'd4;
  localparam logic [2:0] ST_TOO_BIG     = 3'd5;

  localparam logic [1:0] ENC_ASCII  = 2'd0;
  localparam logic [1:0] ENC_UTF8   = 2'd1;
  localparam logic [1:0] ENC_BINARY = 2'd2;

  localparam logic [63:0] MAX10     = 64'h1999_9999_9999_9999;
  localparam logic [3:0]  MAX10_REM = 4'd5;

  localparam int FIFO_DEPTH = 4;

  function automatic dec_t decode(input logic [7:0] c);
    dec_t d;
    d = '{hit: 1'b1, kind: 5'd0, sgn: 2'd0, ord: 3'd0, size: 4'd0, allow: 1'b1};
    unique case (c) inside
      "C": begin d.kind = 5'd3; d.sgn = 2'd1; d.ord = 3'd1; d.size = 4'd1; end
      "S": begin d.kind = 5'd3; d.sgn = 2'd1; d.ord = 3'd2; d.size = 4'd2; end
      "L": begin d.kind = 5'd3; d.sgn = 2'd1; d.ord = 3'd2; d.size = 4'd3; end
      "Q": begin d.kind = 5'd3; d.sgn = 2'd1; d.ord = 3'd2; d.size = 4'd4; end
      "J": begin d.kind = 5'd3; d.sgn = 2'd1; d.ord = 3'd2; d.size = 4'd5; end
      "c": begin d.kind = 5'd3; d.sgn = 2'd2; d.ord = 3'd1; d.size = 4'd1; end
      "s": begin d.kind = 5'd3; d.sgn = 2'd2; d.ord = 3'd2; d.size = 4'd2; end
      "l": begin d.kind = 5'd3; d.sgn = 2'd2; d.ord = 3'd2; d.size = 4'd3; end
      "q": begin d.kind = 5'd3; d.sgn = 2'd2; d.ord = 3'd2; d.size = 4'd4; end
      "j": begin d.kind = 5'd3; d.sgn = 2'd2; d.ord = 3'd2; d.size = 4'd5; end
      "I": begin d.kind = 5'd3; d.sgn = 2'd1; d.ord = 3'd2; d.size = 4'd6; end
      "i": begin d.kind = 5'd3; d.sgn = 2'd2; d.ord = 3'd2; d.size = 4'd6; end
      "n": begin
        d.kind = 5'd3; d.sgn = 2'd1; d.ord = 3'd4; d.size = 4'd2; d.allow = 1'b0;
      end
      "N": begin
        d.kind = 5'd3; d.sgn = 2'd1; d.ord = 3'd4; d.size = 4'd3; d.allow = 1'b0;
      end
      "v": begin
        d.kind = 5'd3; d.sgn = 2'd1; d.ord = 3'd3; d.size = 4'd2; d.allow = 1'b0;
      end
      "V": begin
        d.kind = 5'd3; d.sgn = 2'd1; d.ord = 3'd3; d.size = 4'd3; d.allow = 1'b0;
      end
      "U": d.kind = 5'd4;
      "w": d.kind = 5'd5;
      "D", "d": begin d.kind = 5'd6; d.ord = 3'd2; d.size = 4'd4; end
      "F", "f": begin d.kind = 5'd6; d.ord = 3'd2; d.size = 4'd3; end
      "E": begin d.kind = 5'd6; d.ord = 3'd3; d.size = 4'd4; end
      "e": begin d.kind = 5'd6; d.ord = 3'd3; d.size = 4'd3; end
      "G": begin d.kind = 5'd6; d.ord = 3'd4; d.size = 4'd4; end
      "g": begin d.kind = 5'd6; d.ord = 3'd4; d.size = 4'd3; end
      "A": d.kind = 5'd7;
      "a": d.kind = 5'd8;
      "Z": d.kind = 5'd9;
      "B": d.kind = 5'd10;
      "b": d.kind = 5'd11;
      "H": d.kind = 5'd12;
      "h": d.kind = 5'd13;
      "u": d.kind = 5'd14;
      "M": d.kind = 5'd15;
      "m": d.kind = 5'd16;
      "P": d.kind = 5'd17;
      "p": d.kind = 5'd18;
      "@": d.kind = 5'd19;
      "X": d.kind = 5'd20;
      "x": d.kind = 5'd21;
      default: d.hit = 1'b0;
    endcase
    return d;
  endfunction

  function automatic out_word_t mk_res(input logic [4:0] kind, input logic [1:0] sgn,
                                       input logic [2:0] ord, input logic [3:0] size,
                                       input logic [1:0] ck, input logic [63:0] cnt,
                                       input logic [1:0] enc, input logic [2:0] st);
    out_word_t w;
    w.directive_kind = kind;
    w.signedness     = sgn;
    w.byte_order     = ord;
    w.size_code      = size;
    w.count_kind     = ck;
    w.count_value    = cnt;
    w.encoding_class = enc;
    w.status         = st;
    w.last_of_input  = 1'b0;
    return w;
  endfunction

endpackage
`default_nettype wire

FILE: design/pack_directive_tokenizer_top.sv
// channel | dir | handshake         | word
// in_     | in  | in_valid/in_stall | in_word (char_code, end_of_format)
// out_    | out | out_valid/out_stall | out_word (one result)
// cfg_    | in  | cfg_valid/cfg_ready | cfg_data (unpack_mode)
// One character is taken per cycle unless in_stall is high; a character
// yielding two results writes both into the 4-entry result queue at once.
// Each result is registered into the queue and shown from its head in order.
// Synchronous active-low reset empties the queue and clears parse state.
// in_stall rises when fewer than two queue slots are free.
`timescale 1ns / 1ps
`default_nettype none
module pack_directive_tokenizer_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire pdt_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output pdt_pkg::out_word_t      out_word,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_data
);
  import pdt_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);

  logic          mode_r;
  logic          step, pop;
  out_word_t     res0, res1;
  logic [1:0]    res_cnt;
  out_word_t     mem_r [FIFO_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = cnt_r > (PW+1)'(FIFO_DEPTH - 2);
  assign step      = in_valid && !in_stall;
  assign out_valid = cnt_r != '0;
  assign out_word  = mem_r[rp_r];
  assign pop       = out_valid && !out_stall;

  pdt_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .in_word     (in_word),
    .unpack_mode (mode_r),
    .res0        (res0),
    .res1        (res1),
    .res_cnt     (res_cnt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= 1'b0;
    else if (cfg_valid && cfg_ready) mode_r <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (step && res_cnt != 2'd0) mem_r[wp_r] <= res0;
    if (step && res_cnt == 2'd2) mem_r[wp_r + PW'(1)] <= res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (step) wp_r <= wp_r + PW'(res_cnt);
      if (pop) rp_r <= rp_r + PW'(1);
      cnt_r <= cnt_r + (step ? (PW+1)'(res_cnt) : '0) - (PW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

FILE: design/pdt_core.sv
`timescale 1ns / 1ps
`default_nettype none
module pdt_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire pdt_pkg::in_word_t in_word,
  input  wire logic              unpack_mode,
  output pdt_pkg::out_word_t     res0,
  output pdt_pkg::out_word_t     res1,
  output logic [1:0]             res_cnt
);
  import pdt_pkg::*;

  phase_t      ph_r, ph_nxt;
  logic [4:0]  kind_r, kind_nxt;
  logic [1:0]  sgn_r, sgn_nxt;
  logic [2:0]  ord_r, ord_nxt;
  logic [3:0]  size_r, size_nxt;
  logic [1:0]  ck_r, ck_nxt;
  logic [63:0] cnt_r, cnt_nxt;
  logic        allow_r, allow_nxt;
  logic        ogiven_r, ogiven_nxt;
  logic [1:0]  enc_r, enc_nxt;
  logic        err_r, err_nxt;

  logic [7:0]  c;
  logic        is_ws, is_digit, start;
  logic [3:0]  dig;
  dec_t        dec;
  out_word_t   w;
  logic [63:0] cnt_x10;

  assign c        = in_word.char_code;
  assign is_ws    = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) ||
                    (c == 8'h0C) || (c == 8'h0D);
  assign is_digit = (c >= "0") && (c <= "9");
  assign dig      = 4'(c - "0");
  assign dec      = decode(c);
  assign cnt_x10  = (cnt_r << 3) + (cnt_r << 1);

  always_comb begin
    ph_nxt = ph_r; kind_nxt = kind_r; sgn_nxt = sgn_r; ord_nxt = ord_r;
    size_nxt = size_r; ck_nxt = ck_r; cnt_nxt = cnt_r; allow_nxt = allow_r;
    ogiven_nxt = ogiven_r; enc_nxt = enc_r; err_nxt = err_r;
    res0 = '0; res1 = '0; res_cnt = 2'd0; start = 1'b0; w = '0;

    if (in_word.end_of_format) begin
      if (!err_r && (ph_r == PH_MODS || ph_r == PH_DIGITS)) begin
        if (kind_r == K_UTF8) begin
          if (enc_r == ENC_ASCII) enc_nxt = ENC_UTF8;
        end else if (kind_r != K_UU && kind_r != K_MIME && kind_r != K_B64) begin
          enc_nxt = ENC_BINARY;
        end
        res0    = mk_res(kind_r, sgn_r, ord_r, size_r, ck_r, cnt_r, enc_nxt, ST_OK);
        res_cnt = 2'd1;
      end
      w = mk_res(K_END, 2'd0, 3'd0, 4'd0, 2'd0, 64'd0, enc_nxt, ST_OK);
      if (res_cnt == 2'd1) res1 = w;
      else res0 = w;
      res_cnt = res_cnt + 2'd1;
      ph_nxt = PH_IDLE; kind_nxt = '0; sgn_nxt = '0; ord_nxt = '0; size_nxt = '0;
      ck_nxt = '0; cnt_nxt = '0; allow_nxt = 1'b1; ogiven_nxt = 1'b0;
      enc_nxt = ENC_ASCII; err_nxt = 1'b0;
    end else if (!err_r) begin
      unique case (ph_r) inside
        PH_COMMENT: begin
          if (c == 8'h0A) begin
            ph_nxt  = PH_IDLE;
            res0    = mk_res(K_SPACE, 2'd0, 3'd0, 4'd0, 2'd0, 64'd0, enc_r, ST_OK);
            res_cnt = 2'd1;
          end
        end
        PH_MODS, PH_DIGITS: begin
          if ((ph_r == PH_MODS) && (c == "_" || c == "!")) begin
            if (kind_r != K_INT || !allow_r || size_r == 4'd1) begin
              res0 = mk_res(K_END, 2'd0, 3'd0, 4'd0, 2'd0, 64'd0, enc_r, ST_BANG);
              res_cnt = 2'd1; err_nxt = 1'b1; ph_nxt = PH_IDLE;
            end else if (size_r == 4'd2) size_nxt = 4'd7;
            else if (size_r == 4'd3) size_nxt = 4'd8;
            else if (size_r == 4'd4) size_nxt = 4'd9;
          end else if ((ph_r == PH_MODS) && (c == "<" || c == ">")) begin
            if (ogiven_r) begin
              res0 = mk_res(K_END, 2'd0, 3'd0, 4'd0, 2'd0, 64'd0, enc_r, ST_DOUBLE_END);
              res_cnt = 2'd1; err_nxt = 1'b1; ph_nxt = PH_IDLE;
            end else begin
              ord_nxt    = (c == "<") ? 3'd3 : 3'd4;
              ogiven_nxt = 1'b1;
            end
          end else if ((ph_r == PH_MODS) && is_digit) begin
            ck_nxt  = CK_FIXED;
            cnt_nxt = {60'd0, dig};
            ph_nxt  = PH_DIGITS;
          end else if ((ph_r == PH_DIGITS) && is_digit) begin
            if (cnt_r > MAX10 || (cnt_r == MAX10 && dig > MAX10_REM)) begin
              res0 = mk_res(K_END, 2'd0, 3'd0, 4'd0, 2'd0, 64'd0, enc_r, ST_TOO_BIG);
              res_cnt = 2'd1; err_nxt = 1'b1; ph_nxt = PH_IDLE;
            end else begin
              cnt_nxt = cnt_x10 + {60'd0, dig};
            end
          end else begin
            if ((ph_r == PH_MODS) && (c == "*")) begin
              cnt_nxt = 64'd0;
              case (kind_r) inside
                K_NULL, K_BACK: ck_nxt = unpack_mode ? CK_MAX : CK_FIXED;
                K_MOVE:         ck_nxt = unpack_mode ? CK_REL : CK_FIXED;
                K_UU:           ck_nxt = CK_FIXED;
                K_PFIX: begin
                  ck_nxt = unpack_mode ? CK_MAX : CK_FIXED;
                  if (!unpack_mode) cnt_nxt = 64'd1;
                end
                K_MIME, K_B64: begin ck_nxt = CK_FIXED; cnt_nxt = 64'd1; end
                default:        ck_nxt = CK_MAX;
              endcase
            end else begin
              start = 1'b1;
            end
            if (kind_r == K_UTF8) begin
              if (enc_r == ENC_ASCII) enc_nxt = ENC_UTF8;
            end else if (kind_r != K_UU && kind_r != K_MIME && kind_r != K_B64) begin
              enc_nxt = ENC_BINARY;
            end
            res0    = mk_res(kind_r, sgn_r, ord_r, size_r, ck_nxt, cnt_nxt, enc_nxt, ST_OK);
            res_cnt = 2'd1;
            ph_nxt  = PH_IDLE;
          end
        end
        PH_IDLE: start = 1'b1;
        default: start = 1'b1;
      endcase

      if (start) begin
        w = '0;
        if (is_ws) begin
          w = mk_res(K_SPACE, 2'd0, 3'd0, 4'd0, 2'd0, 64'd0, enc_nxt, ST_OK);
        end else if (c == "#") begin
          w = mk_res(K_CMT, 2'd0, 3'd0, 4'd0, 2'd0, 64'd0, enc_nxt, ST_OK);
          ph_nxt = PH_COMMENT;
        end else if (c == "%") begin
          w = mk_res(K_END, 2'd0, 3'd0, 4'd0, 2'd0, 64'd0, enc_nxt, ST_UNSUPPORTED);
          err_nxt = 1'b1; ph_nxt = PH_IDLE;
        end else if (dec.hit) begin
          kind_nxt = dec.kind; sgn_nxt = dec.sgn; ord_nxt = dec.ord; size_nxt = dec.size;
          allow_nxt = dec.allow; ogiven_nxt = 1'b0; ck_nxt = CK_FIXED;
          cnt_nxt = (unpack_mode && dec.kind == K_MOVE) ? 64'd0 : 64'd1;
          ph_nxt = PH_MODS;
        end else begin
          w = mk_res(K_END, 2'd0, 3'd0, 4'd0, 2'd0, 64'd0, enc_nxt, ST_UNKNOWN);
          err_nxt = 1'b1; ph_nxt = PH_IDLE;
        end
        if (is_ws || c == "#" || c == "%" || !dec.hit) begin
          if (res_cnt == 2'd1) res1 = w;
          else res0 = w;
          res_cnt = res_cnt + 2'd1;
        end
      end
    end

    if (res_cnt == 2'd2) res1.last_of_input = 1'b1;
    else if (res_cnt == 2'd1) res0.last_of_input = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE; kind_r <= '0; sgn_r <= '0; ord_r <= '0; size_r <= '0;
      ck_r <= '0; cnt_r <= '0; allow_r <= 1'b1; ogiven_r <= 1'b0;
      enc_r <= ENC_ASCII; err_r <= 1'b0;
    end else if (step) begin
      ph_r <= ph_nxt; kind_r <= kind_nxt; sgn_r <= sgn_nxt; ord_r <= ord_nxt;
      size_r <= size_nxt; ck_r <= ck_nxt; cnt_r <= cnt_nxt; allow_r <= allow_nxt;
      ogiven_r <= ogiven_nxt; enc_r <= enc_nxt; err_r <= err_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/pdt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module pdt_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire pdt_pkg::out_word_t out_word
);
  import pdt_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed under stall");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status != ST_OK |->
      out_word.directive_kind == K_END && out_word.count_value == 64'd0)
    else $error("error word carries payload");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.directive_kind == K_END && out_word.status == ST_OK |->
      out_word.last_of_input)
    else $error("end word not last");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind pack_directive_tokenizer_top pdt_checker u_pdt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
`default_nettype wire
